// ----- rtl/sul_pkg.sv -----
// ----------------------------------------------------------------------------
// sul_pkg
// Shared types and constants for the user-adaptation payload locator.
// ----------------------------------------------------------------------------
package sul_pkg;

  localparam int MAX_MSG_BYTES = 16384;

  // byte counter saturates at MAX_MSG_BYTES + 1
  localparam int POS_W = $clog2(MAX_MSG_BYTES + 2);
  // parameter start may reach a count position plus a 64K skip
  localparam int NPS_W = ((POS_W > 16) ? POS_W : 16) + 2;

  localparam logic [15:0] TAG_M2UA_DATA1 = 16'h0300;
  localparam logic [15:0] TAG_M2UA_DATA2 = 16'h0301;
  localparam logic [15:0] TAG_M3UA_DATA  = 16'h0210;
  localparam logic [15:0] TAG_M3UA_MTP   = 16'h0002;
  localparam logic [15:0] TAG_M3UA_MTPLI = 16'h0003;

  localparam logic [7:0] HDR_VERSION    = 8'h01;
  localparam logic [7:0] CLASS_M3UA     = 8'h01;
  localparam logic [7:0] CLASS_M2UA     = 8'h06;
  localparam logic [7:0] TYPE_DATA      = 8'h01;
  localparam logic [7:0] SI_NIBBLE_MASK = 8'h0f;

  localparam logic [1:0] OUT_FOUND    = 2'd0;
  localparam logic [1:0] OUT_NOT_DATA = 2'd1;
  localparam logic [1:0] OUT_REJECT   = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_WALK,
    PH_AWAIT_SI,
    PH_FOUND,
    PH_NOT_DATA,
    PH_FAIL
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [7:0]  service_indicator;
    logic [13:0] user_offset;
    logic [14:0] user_length;
  } result_t;

endpackage

// ----- rtl/sul_in_reg.sv -----
// ----------------------------------------------------------------------------
// sul_in_reg
// Input register stage: holds one byte until the parser takes it.
// ----------------------------------------------------------------------------
module sul_in_reg import sul_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     item_valid,
  output in_item_t item,
  input  logic     item_take
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     load;

  assign in_ready   = !valid_r || item_take;
  assign load       = in_valid && in_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- rtl/sul_parser.sv -----
// ----------------------------------------------------------------------------
// sul_parser
// Per-byte header check and tag-length parameter walk, one byte per step.
// ----------------------------------------------------------------------------
module sul_parser import sul_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_item_t item,
  input  logic     mode,
  output logic     push,
  output result_t  result
);

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [7:0]         hb0_r, hb0_nxt, hb1_r, hb1_nxt, hb2_r, hb2_nxt;
  logic [31:0]        decl_r, decl_nxt;
  logic [15:0]        tag_r, tag_nxt;
  logic [15:0]        plen_r, plen_nxt;
  logic [NPS_W-1:0]   nps_r, nps_nxt;
  logic [7:0]         hsi_r, hsi_nxt;
  logic [13:0]        hoff_r, hoff_nxt;
  logic [14:0]        hlen_r, hlen_nxt;

  logic [7:0]         b;
  logic [POS_W-1:0]   pos_inc;
  logic [NPS_W-1:0]   pos_ext;
  logic [NPS_W-1:0]   pdiff;
  logic               in_win;
  logic [31:0]        decl_sh;
  logic [7:0]         cls;
  logic [15:0]        plen_sh;
  logic [15:0]        data_len;
  logic [31:0]        remaining;
  logic               fits;
  logic               is_mtp_tag;
  logic               li;
  logic [15:0]        li5;
  logic               mtp_hit;
  logic               mtp_ok;
  logic [NPS_W-1:0]   mtp_start;
  logic               hit_210;
  logic [16:0]        pad17;
  logic [NPS_W-1:0]   skip_start;
  logic               goto_fail;
  logic               raw_si;

  assign b       = item.data_byte;
  assign pos_inc = (32'(pos_r) <= MAX_MSG_BYTES) ? pos_r + 1'b1 : pos_r;
  assign pos_ext = NPS_W'(pos_r);
  assign pdiff   = pos_ext - nps_r;
  assign in_win  = (pos_ext >= nps_r) && (pdiff < NPS_W'(4));
  assign decl_sh = {decl_r[23:0], b};
  assign cls     = mode ? CLASS_M2UA : CLASS_M3UA;

  // parameter evaluation once its fourth header byte arrives
  assign plen_sh    = {plen_r[7:0], b};
  assign data_len   = plen_sh - 16'd4;
  assign remaining  = decl_r - (32'(nps_r) + 32'd4);
  assign fits       = remaining >= {16'd0, data_len};
  assign is_mtp_tag = mode ? (tag_r == TAG_M2UA_DATA1 || tag_r == TAG_M2UA_DATA2)
                           : (tag_r == TAG_M3UA_MTP || tag_r == TAG_M3UA_MTPLI);
  assign li         = mode ? (tag_r == TAG_M2UA_DATA2) : (tag_r == TAG_M3UA_MTPLI);
  assign li5        = {15'd0, li} + 16'd5;
  // m2ua takes any fitting data tag, m3ua raw mtp3 needs more than the indicator
  assign mtp_hit    = is_mtp_tag && fits && (mode || (data_len > {15'd0, li}));
  assign mtp_ok     = data_len >= li5;
  assign mtp_start  = nps_r + NPS_W'(4) + NPS_W'(li);
  assign hit_210    = !mode && (tag_r == TAG_M3UA_DATA) && (data_len >= 16'd12) && fits;
  assign pad17      = ({1'b0, data_len} + 17'd3) & ~17'd3;
  assign skip_start = nps_r + NPS_W'(4) + NPS_W'(pad17);
  assign goto_fail  = (32'(skip_start) + 32'd4) > decl_r;
  assign raw_si     = !mode && (tag_r == TAG_M3UA_DATA);

  assign push = step && item.last_byte;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    hb0_nxt   = hb0_r;
    hb1_nxt   = hb1_r;
    hb2_nxt   = hb2_r;
    decl_nxt  = decl_r;
    tag_nxt   = tag_r;
    plen_nxt  = plen_r;
    nps_nxt   = nps_r;
    hsi_nxt   = hsi_r;
    hoff_nxt  = hoff_r;
    hlen_nxt  = hlen_r;
    result    = '0;
    result.outcome = OUT_REJECT;

    if (step) begin
      case (phase_r)
        PH_HEADER: begin
          if (pos_r == POS_W'(0)) hb0_nxt = b;
          if (pos_r == POS_W'(2)) hb1_nxt = b;
          if (pos_r == POS_W'(3)) hb2_nxt = b;
          if (pos_r >= POS_W'(4) && pos_r <= POS_W'(7)) decl_nxt = decl_sh;
          if (pos_r == POS_W'(7)) begin
            if (hb0_r != HDR_VERSION) begin
              phase_nxt = PH_FAIL;
            end else if (hb1_r != cls || hb2_r != TYPE_DATA) begin
              phase_nxt = PH_NOT_DATA;
            end else if (decl_sh < 32'd12) begin
              // below 8 is malformed, below 12 leaves no room for a parameter
              phase_nxt = PH_FAIL;
            end else begin
              phase_nxt = PH_WALK;
              nps_nxt   = NPS_W'(8);
            end
          end
        end
        PH_WALK: begin
          if (in_win) begin
            if (!pdiff[1]) begin
              tag_nxt = {tag_r[7:0], b};
            end else begin
              plen_nxt = plen_sh;
            end
            if (pdiff[1:0] == 2'd3) begin
              if (plen_sh < 16'd4) begin
                phase_nxt = PH_FAIL;
              end else if (hit_210) begin
                hoff_nxt  = 14'(nps_r + NPS_W'(16));
                hlen_nxt  = 15'(data_len - 16'd12);
                nps_nxt   = nps_r + NPS_W'(12);
                phase_nxt = PH_AWAIT_SI;
              end else if (mtp_hit) begin
                if (mtp_ok) begin
                  hoff_nxt  = 14'(mtp_start + NPS_W'(5));
                  hlen_nxt  = 15'(data_len - li5);
                  nps_nxt   = mtp_start;
                  phase_nxt = PH_AWAIT_SI;
                end else begin
                  phase_nxt = PH_FAIL;
                end
              end else begin
                nps_nxt = skip_start;
                if (goto_fail) phase_nxt = PH_FAIL;
              end
            end
          end
        end
        PH_AWAIT_SI: begin
          if (pos_ext == nps_r) begin
            hsi_nxt   = raw_si ? b : (b & SI_NIBBLE_MASK);
            phase_nxt = PH_FOUND;
          end
        end
        default: begin
        end
      endcase

      if (item.last_byte) begin
        if (32'(pos_inc) > MAX_MSG_BYTES || pos_inc < POS_W'(8)) begin
          result.outcome = OUT_REJECT;
        end else if (phase_nxt == PH_NOT_DATA) begin
          result.outcome = OUT_NOT_DATA;
        end else if (phase_nxt == PH_FOUND && decl_nxt <= 32'(pos_inc)) begin
          result.outcome           = OUT_FOUND;
          result.service_indicator = hsi_nxt;
          result.user_offset       = hoff_nxt;
          result.user_length       = hlen_nxt;
        end
        // message done: back to the idle message state
        phase_nxt = PH_HEADER;
        pos_nxt   = '0;
        hb0_nxt   = '0;
        hb1_nxt   = '0;
        hb2_nxt   = '0;
        decl_nxt  = '0;
        tag_nxt   = '0;
        plen_nxt  = '0;
        nps_nxt   = NPS_W'(8);
        hsi_nxt   = '0;
        hoff_nxt  = '0;
        hlen_nxt  = '0;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      hb0_r   <= '0;
      hb1_r   <= '0;
      hb2_r   <= '0;
      decl_r  <= '0;
      tag_r   <= '0;
      plen_r  <= '0;
      nps_r   <= NPS_W'(8);
      hsi_r   <= '0;
      hoff_r  <= '0;
      hlen_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      hb0_r   <= hb0_nxt;
      hb1_r   <= hb1_nxt;
      hb2_r   <= hb2_nxt;
      decl_r  <= decl_nxt;
      tag_r   <= tag_nxt;
      plen_r  <= plen_nxt;
      nps_r   <= nps_nxt;
      hsi_r   <= hsi_nxt;
      hoff_r  <= hoff_nxt;
      hlen_r  <= hlen_nxt;
    end
  end

endmodule

// ----- rtl/sul_out_reg.sv -----
// ----------------------------------------------------------------------------
// sul_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sul_out_reg import sul_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data,
  output logic    can_load
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

// ----- rtl/sigtran_ua_payload_locator.sv -----
// ----------------------------------------------------------------------------
// sigtran_ua_payload_locator
// Locates the user payload of an M2UA or M3UA message streamed a byte at a time.
// ----------------------------------------------------------------------------
//
//   channel  | direction | transfer carries
//   ---------+-----------+----------------------------------------------------
//   in_      | in        | data_byte, last_byte (one message byte)
//   out_     | out       | outcome, service_indicator, user_offset, user_length
//   cfg_     | in        | protocol_mode (0 M3UA, 1 M2UA), no handshake
//
// One byte is taken per cycle unless a last byte waits for a free result
// register; the parser's result for a message is held in the result register.
// Reset (synchronous, rst_n low) empties both registers and selects M3UA mode.
// A stalled result register holds back only a last byte; other bytes keep
// flowing through the parser, which updates its state once per byte.
module sigtran_ua_payload_locator import sul_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_outcome,
  output logic [7:0]  out_service_indicator,
  output logic [13:0] out_user_offset,
  output logic [14:0] out_user_length,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  logic     protocol_mode_r, protocol_mode_nxt;
  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     item_take;
  logic     can_load;
  logic     push;
  result_t  result;
  result_t  out_data;

  assign in_item.data_byte = in_data_byte;
  assign in_item.last_byte = in_last_byte;

  // last byte needs a free result slot, other bytes never wait
  assign item_take = item_valid && (!item.last_byte || can_load);

  assign protocol_mode_nxt = cfg_wr_en ? cfg_wr_data : protocol_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protocol_mode_r <= 1'b0;
    end else begin
      protocol_mode_r <= protocol_mode_nxt;
    end
  end

  sul_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  sul_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (item_take),
    .item   (item),
    .mode   (protocol_mode_r),
    .push   (push),
    .result (result)
  );

  sul_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (push),
    .load_data (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .can_load  (can_load)
  );

  assign out_outcome           = out_data.outcome;
  assign out_service_indicator = out_data.service_indicator;
  assign out_user_offset       = out_data.user_offset;
  assign out_user_length       = out_data.user_length;

endmodule
